// File: src/exchange_sorter_defines.svh
// Assertion macros used by the exchange sorter port-level checker.
`ifndef EXCHANGE_SORTER_DEFINES_SVH
`define EXCHANGE_SORTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ES_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/es_pkg.sv
// Shared types and constants of the exchange sorter.
`default_nettype none

package es_pkg;

   localparam int SAMPLE_W = 32;
   localparam int VALUE_W  = 31;

   // What the front end tells the back end to do with one transaction.
   typedef enum logic [1:0] {
      OP_STORE,        // store value, set continues
      OP_STORE_LAST,   // store value, store now full: sort and emit
      OP_FLUSH         // end marker on a non-empty set: sort and emit
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [VALUE_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic                final_flag;
      logic [VALUE_W-1:0]  value;
   } rsp_type;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

endpackage

`default_nettype wire

// File: src/es_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module es_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/es_fifo.sv
// Small register-based FIFO with occupancy output.
`default_nettype none

module es_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           din,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           dout,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push, do_pop;

   assign full    = (level_ff == LVL_W'(DEPTH));
   assign empty   = (level_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slots_ff[rd_ptr_ff];
   assign level   = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

// File: src/es_front.sv
// Front end: accepts samples, classifies them into commands, queues them.
`default_nettype none

module es_front #(
   parameter int CAPACITY = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [es_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  logic                                 cmd_pop,
   output logic                                 cmd_empty,
   output es_pkg::cmd_type                      cmd_data
);

   import es_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             cmd_push;
   cmd_type          cmd_in;
   logic [CMD_W-1:0] cmd_vec;

   assign accept = req_push && !req_full;

   // Negative sample ends the set; an empty set is dropped here.
   always_comb begin
      cmd_in.value = req_sample_value[VALUE_W-1:0];
      cmd_in.op    = OP_STORE;
      cmd_push     = accept;
      count_in     = count_ff;
      if (req_sample_value[SAMPLE_W-1]) begin
         cmd_in.op = OP_FLUSH;
         cmd_push  = accept && (count_ff != '0);
         if (accept) begin
            count_in = '0;
         end
      end else if (count_ff == CNT_W'(CAPACITY-1)) begin
         cmd_in.op = OP_STORE_LAST;
         if (accept) begin
            count_in = '0;
         end
      end else if (accept) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   es_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (4)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_in),
      .full  (req_full),
      .pop   (cmd_pop),
      .dout  (cmd_vec),
      .empty (cmd_empty),
      .level ()
   );

   assign cmd_data = cmd_type'(cmd_vec);

endmodule

`default_nettype wire

// File: src/es_back.sv
// Back end: stores samples, runs the exchange sort in RAM, emits results.
`default_nettype none

module es_back #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_empty,
   input  es_pkg::cmd_type               cmd_data,
   output logic                          cmd_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [es_pkg::VALUE_W-1:0]    rsp_sorted_value,
   output logic                          rsp_final_flag
);

   import es_pkg::*;

   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int FILL_W    = $clog2(CAPACITY+1);
   localparam int OUT_DEPTH = 4;
   localparam int OUT_LVL_W = $clog2(OUT_DEPTH+1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_LAST = 3'd3;
   localparam logic [2:0] ST_WB   = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   // What the RAM read data of this cycle is for.
   localparam logic [1:0] RD_NONE = 2'd0;
   localparam logic [1:0] RD_HELD = 2'd1;
   localparam logic [1:0] RD_CMP  = 2'd2;
   localparam logic [1:0] RD_OUT  = 2'd3;

   logic [2:0]         state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0]  i_ff, i_in;
   logic [ADDR_W-1:0]  j_ff, j_in;
   logic [VALUE_W-1:0] held_ff, held_in;
   logic [1:0]         tag_ff, tag_in;
   logic [ADDR_W-1:0]  tag_addr_ff, tag_addr_in;
   logic               tag_last_ff, tag_last_in;

   logic               ram_we, ram_re;
   logic [ADDR_W-1:0]  ram_wa, ram_ra;
   logic [VALUE_W-1:0] ram_wd, ram_rd;

   logic               out_push, out_full;
   rsp_type            out_din, out_dout;
   logic [RSP_W-1:0]   out_vec;
   logic [OUT_LVL_W-1:0] out_level;
   logic [OUT_LVL_W:0]   out_used;
   logic [ADDR_W-1:0]  last_idx;

   assign last_idx = ADDR_W'(fill_ff - FILL_W'(1));
   assign out_used = (OUT_LVL_W+1)'(out_level) + (OUT_LVL_W+1)'(tag_ff == RD_OUT);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      held_in     = held_ff;
      tag_in      = RD_NONE;
      tag_addr_in = j_ff;
      tag_last_in = 1'b0;
      ram_we      = 1'b0;
      ram_wa      = tag_addr_ff;
      ram_wd      = held_ff;
      ram_re      = 1'b0;
      ram_ra      = j_ff;
      cmd_pop     = 1'b0;
      out_push    = 1'b0;
      out_din.value      = ram_rd;
      out_din.final_flag = tag_last_ff;

      // Read-data stage; runs independently of the sequencer state.
      unique case (tag_ff)
         RD_HELD: held_in = ram_rd;
         RD_CMP: begin
            if (ram_rd > held_ff) begin
               ram_we  = 1'b1;
               ram_wa  = tag_addr_ff;
               ram_wd  = held_ff;
               held_in = ram_rd;
            end
         end
         RD_OUT:  out_push = 1'b1;
         default: ;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               unique case (cmd_data.op)
                  OP_STORE: begin
                     ram_we  = 1'b1;
                     ram_wa  = fill_ff[ADDR_W-1:0];
                     ram_wd  = cmd_data.value;
                     fill_in = fill_ff + FILL_W'(1);
                  end
                  OP_STORE_LAST: begin
                     ram_we   = 1'b1;
                     ram_wa   = fill_ff[ADDR_W-1:0];
                     ram_wd   = cmd_data.value;
                     fill_in  = fill_ff + FILL_W'(1);
                     i_in     = '0;
                     state_in = ST_LOAD;
                  end
                  OP_FLUSH: begin
                     i_in     = '0;
                     state_in = ST_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            ram_re   = 1'b1;
            ram_ra   = i_ff;
            tag_in   = RD_HELD;
            j_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            ram_re      = 1'b1;
            ram_ra      = j_ff;
            tag_in      = (j_ff == i_ff) ? RD_NONE : RD_CMP;
            tag_addr_in = j_ff;
            if (j_ff == last_idx) begin
               state_in = ST_LAST;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_LAST: state_in = ST_WB;
         ST_WB: begin
            ram_we = 1'b1;
            ram_wa = i_ff;
            ram_wd = held_ff;
            if (i_ff == last_idx) begin
               j_in     = '0;
               state_in = ST_EMIT;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (out_used < (OUT_LVL_W+1)'(OUT_DEPTH)) begin
               ram_re      = 1'b1;
               ram_ra      = j_ff;
               tag_in      = RD_OUT;
               tag_last_in = (j_ff == last_idx);
               if (j_ff == last_idx) begin
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         tag_ff   <= RD_NONE;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         tag_ff   <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      held_ff     <= held_in;
      tag_addr_ff <= tag_addr_in;
      tag_last_ff <= tag_last_in;
   end

   es_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   es_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_din),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (out_vec),
      .empty (rsp_empty),
      .level (out_level)
   );

   // Room is reserved before each read, so the queue never overflows.
   assign out_dout         = rsp_type'(out_vec);
   assign rsp_sorted_value = out_dout.value;
   assign rsp_final_flag   = out_dout.final_flag && !out_full ? out_dout.final_flag
                                                              : out_dout.final_flag;

endmodule

`default_nettype wire

// File: src/exchange_sorter.sv
// Samples load into the RAM at one per cycle while commands are waiting; the
// exchange sort then runs over the RAM (load, scan, last and write-back for
// each outer index), and results leave one per cycle while the result queue
// has room. A new set is not loaded until the last one has been emitted.
// Reset (synchronous, active high) empties both queues and the set in progress;
// the sample RAM itself is not cleared and needs no clearing pass.
`default_nettype none

module exchange_sorter #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel: push while not full.
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [es_pkg::SAMPLE_W-1:0]  req_sample_value,
   // Result channel: oldest result shown while not empty; pop takes it.
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [es_pkg::VALUE_W-1:0]          rsp_sorted_value,
   output logic                                rsp_final_flag
);

   import es_pkg::*;

   // Command queue between the two halves. The front keeps accepting
   // transactions (up to the queue depth) while the back sorts or emits.
   logic    cmd_empty;
   logic    cmd_pop;
   cmd_type cmd_data;

   // Front: splits each sample into store / store-and-sort / flush,
   // and silently drops an end marker that arrives on an empty set.
   es_front #(
      .CAPACITY (CAPACITY)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_sample_value (req_sample_value),
      .cmd_pop          (cmd_pop),
      .cmd_empty        (cmd_empty),
      .cmd_data         (cmd_data)
   );

   // Back: writes samples into the RAM, runs the i/j exchange sort with one
   // compare per cycle during each scan, then streams the sorted set into the result queue
   // with the final flag on its last entry.
   es_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_empty        (cmd_empty),
      .cmd_data         (cmd_data),
      .cmd_pop          (cmd_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_flag   (rsp_final_flag)
   );

endmodule

`default_nettype wire

// File: src/es_checker.sv
// Port-level checker for the exchange sorter, bound to the top level.
`default_nettype none

`include "exchange_sorter_defines.svh"

module es_checker #(
   parameter int CAPACITY = 64
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_empty,
   input logic                       rsp_pop,
   input logic [es_pkg::VALUE_W-1:0] rsp_sorted_value,
   input logic                       rsp_final_flag
);

   localparam int CNT_W = $clog2(CAPACITY);

   logic                       taken;
   logic                       in_set_ff;
   logic [es_pkg::VALUE_W-1:0] last_ff;
   logic [CNT_W-1:0]           cnt_ff;

   assign taken = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_set_ff <= 1'b0;
         cnt_ff    <= '0;
      end else if (taken) begin
         in_set_ff <= !rsp_final_flag;
         cnt_ff    <= rsp_final_flag ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (taken) begin
         last_ff <= rsp_sorted_value;
      end
   end

   `ES_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_sorted_value) && $stable(rsp_final_flag), "result changed while waiting")
   `ES_ASSERT_SAME(a_ascending, clock, reset, taken && in_set_ff, rsp_sorted_value >= last_ff, "results of a set not ascending")
   `ES_ASSERT_SAME(a_set_size, clock, reset, taken && !rsp_final_flag, cnt_ff < CNT_W'(CAPACITY-1), "set longer than capacity")
   `ES_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty, "results present after reset")

endmodule

bind exchange_sorter es_checker #(.CAPACITY(CAPACITY)) u_es_checker (.*);

`default_nettype wire

// File: bench/exchange_sorter_check.sv
// Checker for the exchange sorter: predicts each sorted set and compares every result.
module exchange_sorter_check #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  logic                                req_full,
   input  logic signed [es_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic                                rsp_empty,
   input  logic                                rsp_pop,
   input  logic [es_pkg::VALUE_W-1:0]          rsp_sorted_value,
   input  logic                                rsp_final_flag,
   output int unsigned                         fail_count,
   output int unsigned                         results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   logic [es_pkg::VALUE_W-1:0] open_set[$];   // values of the set being collected
   es_pkg::rsp_type            sorted_due[$]; // predicted results, oldest first
   es_pkg::rsp_type            head;

   initial begin
      fail_count  = 0;
      results_due = 0;
   end

   task automatic note_failure(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
   endtask

   // Exchange sort of the open set, then one predicted result per value.
   task automatic release_set();
      logic [es_pkg::VALUE_W-1:0] vals[CAPACITY];
      logic [es_pkg::VALUE_W-1:0] held;
      es_pkg::rsp_type            entry;
      int                         n;
      n = open_set.size();
      for (int k = 0; k < n; k++) vals[k] = open_set[k];
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            if (vals[j] > vals[i]) begin
               held    = vals[i];
               vals[i] = vals[j];
               vals[j] = held;
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         entry.value      = vals[k];
         entry.final_flag = (k == n - 1);
         sorted_due.push_back(entry);
      end
      open_set.delete();
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            if (req_sample_value[es_pkg::SAMPLE_W-1]) begin
               // end marker; on an empty set it is dropped
               if (open_set.size() != 0) release_set();
            end else begin
               open_set.push_back(req_sample_value[es_pkg::VALUE_W-1:0]);
               if (open_set.size() == CAPACITY) release_set();
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (sorted_due.size() == 0) begin
               note_failure("unexpected result (none due)", 32'd0, 32'(rsp_sorted_value));
            end else begin
               head = sorted_due.pop_front();
               if (rsp_sorted_value !== head.value)
                  note_failure("sorted_value", 32'(head.value), 32'(rsp_sorted_value));
               if (rsp_final_flag !== head.final_flag)
                  note_failure("final_flag", 32'(head.final_flag), 32'(rsp_final_flag));
            end
         end
      end
      results_due <= sorted_due.size();
   end

endmodule

// File: bench/exchange_sorter_test.sv
// Testbench top for the exchange sorter: stimulus, handshake pacing, watchdog and verdict.
module exchange_sorter_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_CAP      = 64;
   localparam int RANDOM_ITEMS = 410;
   // A full set sorts with no transaction on either side, so the idle limit
   // sits several times above the time that sort takes.
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 100;

   // All inputs start at known values; reset is high from time zero.
   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                req_push         = 1'b0;
   logic                                req_full;
   logic signed [es_pkg::SAMPLE_W-1:0]  req_sample_value = '0;
   logic                                rsp_empty;
   logic                                rsp_pop          = 1'b0;
   logic [es_pkg::VALUE_W-1:0]          rsp_sorted_value;
   logic                                rsp_final_flag;

   int unsigned fail_count;
   int unsigned results_due;
   int unsigned idle_cycles   = 0;
   int unsigned counted_items = 0;
   bit          push_steady   = 1'b0;  // when set, the sender runs without gaps
   bit          pop_steady    = 1'b0;  // when set, the receiver never stalls

   initial begin
      forever #4 clock = ~clock;
   end

   exchange_sorter #(
      .CAPACITY(SET_CAP)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_sample_value(req_sample_value),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_final_flag  (rsp_final_flag)
   );

   exchange_sorter_check #(
      .CAPACITY(SET_CAP)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_sample_value(req_sample_value),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_final_flag  (rsp_final_flag),
      .fail_count      (fail_count),
      .results_due     (results_due)
   );

   // One input transaction. Always entered right after a rising edge.
   // push stays high across back-to-back transactions, so it is only
   // lowered when a gap is drawn.
   task automatic send_sample(input logic signed [31:0] sample);
      int unsigned gap;
      if ($urandom_range(0, 19) == 0) push_steady = !push_steady;
      gap = push_steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_sample_value <= sample;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Any negative value ends a set; the low bits are random in half the picks, so they toggle too.
   function automatic logic signed [31:0] end_marker();
      case ($urandom_range(0, 3))
         0:       return 32'sh8000_0000;
         1:       return -1;
         default: return {1'b1, 31'($urandom)};
      endcase
   endfunction

   // A set of n values; a full set ends on its own, anything shorter
   // gets an end marker. Small values make duplicates likely.
   task automatic send_set(input int n);
      logic signed [31:0] sample;
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0:          sample = 32'sh0000_0000;
            1:          sample = 32'sh7FFF_FFFF;
            2, 3, 4:    sample = $urandom_range(0, 15);
            default:    sample = {1'b0, 31'($urandom)};
         endcase
         send_sample(sample);
      end
      counted_items += n;
      if (n < SET_CAP) begin
         send_sample(end_marker());
         counted_items++;
      end
   endtask

   // Result side: a random stall before each transaction, with
   // stretches of continuous popping. pop stays high while the next stall is zero.
   initial begin : result_sink
      int unsigned stall;
      forever begin
         if ($urandom_range(0, 19) == 0) pop_steady = !pop_steady;
         stall = pop_steady ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   // Watchdog: too long without a transaction on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      send_sample(32'sh8000_0000);     // end marker with nothing stored: no result
      send_sample(32'sh7FFF_FFFF);     // largest value, twice, with zero and duplicates
      send_sample(32'sh0000_0000);
      send_sample(32'sh0000_0005);
      send_sample(32'sh0000_0005);
      send_sample(32'sh0000_0001);
      send_sample(32'sh7FFF_FFFF);
      send_sample(-1);
      send_sample(32'sh2AAA_AAAA);     // single-value set, alternating bits
      send_sample(32'shD555_5555);
      send_sample(32'sh5555_5555);
      send_sample(32'sh0000_0000);
      send_sample(32'shFFFF_FFFF);
      send_sample(-1);                 // empty set once more

      // Random part: the first set fills the store, the rest mostly small
      // sets, a few medium, one short of full, or full, with stray end
      // markers between sets as noise.
      send_set(SET_CAP);
      while (counted_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) send_sample(end_marker());
         pick = $urandom_range(0, 99);
         if (pick < 4)
            send_set(SET_CAP);
         else if (pick < 7)
            send_set(SET_CAP - 1);
         else if (pick < 17)
            send_set($urandom_range(9, 30));
         else
            send_set($urandom_range(1, 8));
      end
      req_push <= 1'b0;

      // results_due is registered, so it is read only after the next edge.
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
